[hw/rtl/cdll_pkg.sv]
package cdll_pkg;

    localparam int unsigned DataW = 32;

    typedef enum logic [2:0] {
        OP_INS_BEFORE = 3'd0,
        OP_INS_AFTER  = 3'd1,
        OP_CUR_HEAD   = 3'd2,
        OP_CUR_TAIL   = 3'd3,
        OP_CUR_BACK   = 3'd4,
        OP_CUR_FWD    = 3'd5,
        OP_LIST_FWD   = 3'd6,
        OP_LIST_BACK  = 3'd7
    } t_op;

    typedef enum logic [2:0] {
        ST_DONE     = 3'd0,
        ST_NEW_HEAD = 3'd1,
        ST_NEW_TAIL = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_NO_MOVE  = 3'd4,
        ST_FULL     = 3'd5,
        ST_ELEMENT  = 3'd6
    } t_status;

    // One result word handed from the sequencer to the output register.
    typedef struct packed {
        logic                    valid;
        t_status                 status;
        logic signed [DataW-1:0] element;
        logic                    last;
    } t_emit;

    // Write strobes of the three node memories.
    typedef struct packed {
        logic val;
        logic nxt;
        logic prv;
    } t_wen;

endpackage

[hw/rtl/cdll_ram.sv]
module cdll_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/cdll_seq.sv]
module cdll_seq
    import cdll_pkg::*;
#(
    parameter int unsigned NODES = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  t_op                        i_op,
    input  logic signed [DataW-1:0]    i_value,
    input  logic                       i_slot_free,
    output t_emit                      o_emit,
    output logic [$clog2(NODES)-1:0]   o_raddr,
    output t_wen                       o_wen,
    output logic [$clog2(NODES)-1:0]   o_val_waddr,
    output logic [DataW-1:0]           o_val_wdata,
    output logic [$clog2(NODES)-1:0]   o_nxt_waddr,
    output logic [$clog2(NODES):0]     o_nxt_wdata,
    output logic [$clog2(NODES)-1:0]   o_prv_waddr,
    output logic [$clog2(NODES):0]     o_prv_wdata,
    input  logic signed [DataW-1:0]    i_val_rdata,
    input  logic [$clog2(NODES):0]     i_nxt_rdata,
    input  logic [$clog2(NODES):0]     i_prv_rdata
);

    localparam int unsigned IW = $clog2(NODES);
    localparam int unsigned UW = $clog2(NODES + 1);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_INSERT = 6'b000010,
        S_SPLICE = 6'b000100,
        S_MOVE   = 6'b001000,
        S_LIST   = 6'b010000,
        S_RESP   = 6'b100000
    } t_state;

    t_state                  r_state, n_state;
    logic [IW-1:0]           r_head, n_head;
    logic [IW-1:0]           r_tail, n_tail;
    logic [IW-1:0]           r_cur, n_cur;
    logic [UW-1:0]           r_used, n_used;
    logic [UW-1:0]           r_cnt, n_cnt;
    logic [IW-1:0]           r_addr, n_addr;
    t_op                     r_op, n_op;
    logic signed [DataW-1:0] r_value, n_value;
    logic [IW-1:0]           r_p, n_p;
    logic [IW-1:0]           r_nb, n_nb;
    logic                    r_edge, n_edge;
    t_status                 r_status, n_status;

    logic          empty;
    logic          full;
    logic          at_end;
    logic [IW:0]   walk_link;
    logic          fin;

    assign empty = (r_used == '0);
    assign full  = (r_used == UW'(NODES));

    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_tail   = r_tail;
        n_cur    = r_cur;
        n_used   = r_used;
        n_cnt    = r_cnt;
        n_op     = r_op;
        n_value  = r_value;
        n_p      = r_p;
        n_nb     = r_nb;
        n_edge   = r_edge;
        n_status = r_status;
        o_ready      = (r_state == S_IDLE);
        o_emit       = '0;
        o_raddr      = r_addr;
        o_wen        = '0;
        o_val_waddr  = r_p;
        o_val_wdata  = r_value;
        o_nxt_waddr  = r_p;
        o_nxt_wdata  = '0;
        o_prv_waddr  = r_p;
        o_prv_wdata  = '0;
        at_end       = 1'b0;
        walk_link    = (r_op == OP_LIST_BACK) ? i_prv_rdata : i_nxt_rdata;
        fin          = !walk_link[IW] || ((r_cnt + 1'b1) == r_used);

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_op    = i_op;
                    n_value = i_value;
                    n_p     = r_used[IW-1:0];
                    n_cnt   = '0;
                    case (i_op)
                        OP_INS_BEFORE, OP_INS_AFTER: begin
                            o_raddr = r_cur;
                            if (full) begin
                                n_status = ST_FULL;
                                n_state  = S_RESP;
                            end else begin
                                n_state = S_INSERT;
                            end
                        end
                        OP_CUR_HEAD: begin
                            n_state = S_RESP;
                            if (empty) begin
                                n_status = ST_EMPTY;
                            end else if (r_cur == r_head) begin
                                n_status = ST_NO_MOVE;
                            end else begin
                                n_cur    = r_head;
                                n_status = ST_DONE;
                            end
                        end
                        OP_CUR_TAIL: begin
                            n_state = S_RESP;
                            if (empty) begin
                                n_status = ST_EMPTY;
                            end else if (r_cur == r_tail) begin
                                n_status = ST_NO_MOVE;
                            end else begin
                                n_cur    = r_tail;
                                n_status = ST_DONE;
                            end
                        end
                        OP_CUR_BACK, OP_CUR_FWD: begin
                            o_raddr = r_cur;
                            if (empty) begin
                                n_status = ST_EMPTY;
                                n_state  = S_RESP;
                            end else begin
                                n_state = S_MOVE;
                            end
                        end
                        OP_LIST_FWD, OP_LIST_BACK: begin
                            o_raddr = (i_op == OP_LIST_BACK) ? r_tail : r_head;
                            if (empty) begin
                                n_status = ST_EMPTY;
                                n_state  = S_RESP;
                            end else begin
                                n_state = S_LIST;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_INSERT: begin
                // The link words of the cursor node are on the read ports now.
                o_wen.val = 1'b1;
                o_wen.nxt = 1'b1;
                o_wen.prv = 1'b1;
                n_used    = r_used + 1'b1;
                if (empty) begin
                    n_head   = r_p;
                    n_tail   = r_p;
                    n_cur    = r_p;
                    n_status = ST_NEW_HEAD;
                    n_state  = S_RESP;
                end else if (r_op == OP_INS_BEFORE) begin
                    at_end      = (r_cur == r_head) || !i_prv_rdata[IW];
                    o_nxt_wdata = {1'b1, r_cur};
                    o_prv_wdata = at_end ? '0 : {1'b1, i_prv_rdata[IW-1:0]};
                    n_nb        = i_prv_rdata[IW-1:0];
                    n_edge      = at_end;
                    n_status    = at_end ? ST_NEW_HEAD : ST_DONE;
                    if (at_end) begin
                        n_head = r_p;
                    end
                    n_state = S_SPLICE;
                end else begin
                    at_end      = (r_cur == r_tail) || !i_nxt_rdata[IW];
                    o_prv_wdata = {1'b1, r_cur};
                    o_nxt_wdata = at_end ? '0 : {1'b1, i_nxt_rdata[IW-1:0]};
                    n_nb        = i_nxt_rdata[IW-1:0];
                    n_edge      = at_end;
                    n_status    = at_end ? ST_NEW_TAIL : ST_DONE;
                    if (at_end) begin
                        n_tail = r_p;
                    end
                    n_state = S_SPLICE;
                end
            end
            S_SPLICE: begin
                // Point the cursor node and, in the middle, its old neighbor at the new node.
                o_nxt_wdata = {1'b1, r_p};
                o_prv_wdata = {1'b1, r_p};
                if (r_op == OP_INS_BEFORE) begin
                    o_wen.prv   = 1'b1;
                    o_prv_waddr = r_cur;
                    o_wen.nxt   = !r_edge;
                    o_nxt_waddr = r_nb;
                end else begin
                    o_wen.nxt   = 1'b1;
                    o_nxt_waddr = r_cur;
                    o_wen.prv   = !r_edge;
                    o_prv_waddr = r_nb;
                end
                n_state = S_RESP;
            end
            S_MOVE: begin
                if ((r_op == OP_CUR_BACK) ? i_prv_rdata[IW] : i_nxt_rdata[IW]) begin
                    n_cur    = (r_op == OP_CUR_BACK) ? i_prv_rdata[IW-1:0]
                                                     : i_nxt_rdata[IW-1:0];
                    n_status = ST_DONE;
                end else begin
                    n_status = ST_NO_MOVE;
                end
                n_state = S_RESP;
            end
            S_LIST: begin
                if (i_slot_free) begin
                    o_emit.valid   = 1'b1;
                    o_emit.status  = ST_ELEMENT;
                    o_emit.element = i_val_rdata;
                    o_emit.last    = fin;
                    if (fin) begin
                        n_state = S_IDLE;
                    end else begin
                        o_raddr = walk_link[IW-1:0];
                        n_cnt   = r_cnt + 1'b1;
                    end
                end
            end
            S_RESP: begin
                if (i_slot_free) begin
                    o_emit.valid  = 1'b1;
                    o_emit.status = r_status;
                    o_emit.last   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_addr = o_raddr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_cur   <= '0;
            r_used  <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_cur   <= n_cur;
            r_used  <= n_used;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr   <= n_addr;
        r_op     <= n_op;
        r_value  <= n_value;
        r_p      <= n_p;
        r_nb     <= n_nb;
        r_edge   <= n_edge;
        r_status <= n_status;
    end

endmodule

[hw/rtl/cursor_doubly_linked_list_top.sv]
// Path from input accept to the result word on the output: cursor to head or tail via S_RESP,
// step back or forward via S_MOVE and S_RESP, insert via S_INSERT, S_SPLICE and S_RESP (S_INSERT
// and S_RESP into an empty list); listing emits one element per cycle while the output is taken.
// One request at a time: the next is accepted once the last word has entered the output register.
// Reset is synchronous and empties the list; the node memories are not cleared.
module cursor_doubly_linked_list_top
    import cdll_pkg::*;
#(
    parameter int unsigned NODES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [2:0] op, [34:3] value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [2:0] status, [34:3] element
    output logic        m_axis_tlast
);

    localparam int unsigned IW = $clog2(NODES);

    t_emit                   emit;
    t_wen                    wen;
    logic [IW-1:0]           raddr;
    logic [IW-1:0]           val_waddr;
    logic [DataW-1:0]        val_wdata;
    logic [IW-1:0]           nxt_waddr;
    logic [IW:0]             nxt_wdata;
    logic [IW-1:0]           prv_waddr;
    logic [IW:0]             prv_wdata;
    logic [DataW-1:0]        val_rdata;
    logic [IW:0]             nxt_rdata;
    logic [IW:0]             prv_rdata;
    logic                    slot_free;

    logic                    r_ovalid;
    t_status                 r_ostatus;
    logic signed [DataW-1:0] r_oelem;
    logic                    r_olast;

    assign slot_free = !r_ovalid || m_axis_tready;

    cdll_seq #(
        .NODES (NODES)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_op        (t_op'(s_axis_tdata[2:0])),
        .i_value     (signed'(s_axis_tdata[34:3])),
        .i_slot_free (slot_free),
        .o_emit      (emit),
        .o_raddr     (raddr),
        .o_wen       (wen),
        .o_val_waddr (val_waddr),
        .o_val_wdata (val_wdata),
        .o_nxt_waddr (nxt_waddr),
        .o_nxt_wdata (nxt_wdata),
        .o_prv_waddr (prv_waddr),
        .o_prv_wdata (prv_wdata),
        .i_val_rdata (signed'(val_rdata)),
        .i_nxt_rdata (nxt_rdata),
        .i_prv_rdata (prv_rdata)
    );

    cdll_ram #(
        .WIDTH (DataW),
        .DEPTH (NODES)
    ) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (wen.val),
        .i_waddr (val_waddr),
        .i_wdata (val_wdata),
        .i_raddr (raddr),
        .o_rdata (val_rdata)
    );

    // Link words carry a valid bit above the node index.
    cdll_ram #(
        .WIDTH (IW + 1),
        .DEPTH (NODES)
    ) u_nxt_ram (
        .i_clk   (i_clk),
        .i_we    (wen.nxt),
        .i_waddr (nxt_waddr),
        .i_wdata (nxt_wdata),
        .i_raddr (raddr),
        .o_rdata (nxt_rdata)
    );

    cdll_ram #(
        .WIDTH (IW + 1),
        .DEPTH (NODES)
    ) u_prv_ram (
        .i_clk   (i_clk),
        .i_we    (wen.prv),
        .i_waddr (prv_waddr),
        .i_wdata (prv_wdata),
        .i_raddr (raddr),
        .o_rdata (prv_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (emit.valid) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit.valid) begin
            r_ostatus <= emit.status;
            r_oelem   <= emit.element;
            r_olast   <= emit.last;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {5'b0, r_oelem, r_ostatus};
    assign m_axis_tlast  = r_olast;

endmodule

[hw/rtl/cdll_chk.sv]
module cdll_chk
    import cdll_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [39:0] s_axis_tdata,   // [2:0] op, [34:3] value
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,   // [2:0] status, [34:3] element
    input logic        m_axis_tlast
);

    // A request keeps the sequencer busy, so two requests are never accepted back to back.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted in two consecutive cycles");

    // Only listed elements may be followed by more words of the same request.
    a_single_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[2:0] != ST_ELEMENT) |-> m_axis_tlast)
        else $error("status word without last");

    a_element_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[2:0] != ST_ELEMENT) |-> (m_axis_tdata[34:3] == '0))
        else $error("nonzero element on a status word");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output word changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

bind cursor_doubly_linked_list_top cdll_chk u_chk (.*);
